// ===== src/teet_pkg.sv =====
`default_nettype none

package teet_pkg;

    // Fixed port widths of the item and result fields.
    localparam int MODE_W       = 2;
    localparam int PORT_PAYLOAD_W = 64;
    localparam int LIFE_W       = 21;
    localparam int ELAPSED_W    = 20;
    localparam int INDEX_W      = 6;
    localparam int STATUS_W     = 2;
    localparam int COUNT_W      = 7;
    localparam int PORT_TIME_W  = 20;

    // Operation carried by an input beat.
    typedef enum logic [MODE_W-1:0] {
        MODE_ADD  = 2'd0,
        MODE_ADV  = 2'd1,
        MODE_READ = 2'd2,
        MODE_NOP  = 2'd3
    } mode_t;

    // Completion code carried by a result beat.
    typedef enum logic [STATUS_W-1:0] {
        STAT_DONE = 2'd0,
        STAT_NEG  = 2'd1,
        STAT_FULL = 2'd2
    } status_t;

    // Control sequencer states.
    typedef enum logic [1:0] {
        S_IDLE,
        S_ADV,
        S_RDATA,
        S_DONE
    } state_t;

endpackage

`default_nettype wire

// ===== src/timed_entry_expiry_table.sv =====
// Timed entry table with in-place expiry.
// Input channel: in_valid / in_stall with mode, endpoint_a, endpoint_b, lifetime_ms,
// elapsed_ms and read_index. Output channel: out_valid / out_stall with status,
// live_count, read_valid and the three read fields. Every input beat yields one
// result beat.
// Add, read and no-op beats go from idle to one result state (S_DONE or S_RDATA),
// which loads the output register once it is free and returns to idle for the next beat.
// An advance runs in S_ADV (skipped when the table is empty) and then S_DONE: the
// sequencer streams one entry per cycle through the single read port of the entry
// memory and writes survivors back, compacted, through the write port.
// The block works on one beat at a time; in_stall is high while a beat is in work.
// A finished result sits in the output register, so the next beat is accepted while
// the previous result waits; a result that cannot be handed over stalls the block.
// Reset clears the live count, the sequencer and the output valid; the entry memory
// is not cleared, and only entries below the live count are ever read.
`default_nettype none

module timed_entry_expiry_table #(
    parameter int MAX_ENTRIES   = 64,
    parameter int PAYLOAD_WIDTH = 64,
    parameter int TIME_WIDTH    = 20
) (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire logic                                  in_valid,
    output logic                                       in_stall,
    input  wire logic [teet_pkg::MODE_W-1:0]           mode,
    input  wire logic [teet_pkg::PORT_PAYLOAD_W-1:0]   endpoint_a,
    input  wire logic [teet_pkg::PORT_PAYLOAD_W-1:0]   endpoint_b,
    input  wire logic signed [teet_pkg::LIFE_W-1:0]    lifetime_ms,
    input  wire logic [teet_pkg::ELAPSED_W-1:0]        elapsed_ms,
    input  wire logic [teet_pkg::INDEX_W-1:0]          read_index,
    output logic                                       out_valid,
    input  wire logic                                  out_stall,
    output logic [teet_pkg::STATUS_W-1:0]              status,
    output logic [teet_pkg::COUNT_W-1:0]               live_count,
    output logic                                       read_valid,
    output logic [teet_pkg::PORT_PAYLOAD_W-1:0]        read_endpoint_a,
    output logic [teet_pkg::PORT_PAYLOAD_W-1:0]        read_endpoint_b,
    output logic [teet_pkg::PORT_TIME_W-1:0]           read_remaining_ms
);

    localparam int PW = PAYLOAD_WIDTH;
    localparam int TW = TIME_WIDTH;
    localparam int AW = $clog2(MAX_ENTRIES);
    localparam int CW = $clog2(MAX_ENTRIES + 1);
    localparam int DW = 2 * PW + TW;
    localparam int SW = (TW > teet_pkg::ELAPSED_W) ? TW : teet_pkg::ELAPSED_W;
    localparam int IW = (CW > teet_pkg::INDEX_W) ? CW : teet_pkg::INDEX_W;
    localparam int LW = (CW > teet_pkg::COUNT_W) ? CW : teet_pkg::COUNT_W;
    localparam int RW = (TW > teet_pkg::PORT_TIME_W) ? TW : teet_pkg::PORT_TIME_W;
    localparam logic [TW-1:0] TIME_MAX = '1;
    localparam logic [CW-1:0] COUNT_FULL = CW'(MAX_ENTRIES);

    // Control state.
    teet_pkg::state_t  state_reg, state_next;
    logic [CW-1:0]     count_reg, count_next;
    logic [CW-1:0]     rd_reg, rd_next;
    logic [CW-1:0]     wr_reg, wr_next;
    logic              pend_reg, pend_next;
    logic              hit_reg, hit_next;
    teet_pkg::status_t status_reg, status_next;
    logic [teet_pkg::ELAPSED_W-1:0] elapsed_reg, elapsed_next;
    logic              out_valid_reg, out_valid_next;

    // Result payload registers.
    teet_pkg::status_t                    out_status_reg;
    logic [teet_pkg::COUNT_W-1:0]         out_count_reg;
    logic                                 out_hit_reg;
    logic [teet_pkg::PORT_PAYLOAD_W-1:0]  out_a_reg;
    logic [teet_pkg::PORT_PAYLOAD_W-1:0]  out_b_reg;
    logic [teet_pkg::PORT_TIME_W-1:0]     out_rem_reg;

    // Entry memory ports.
    logic          ram_wr_en;
    logic [AW-1:0] ram_wr_addr;
    logic [DW-1:0] ram_wr_data;
    logic          ram_rd_en;
    logic [AW-1:0] ram_rd_addr;
    logic [DW-1:0] ram_rd_data;

    // Helper values.
    logic          in_accept;
    logic          out_free;
    logic          out_load;
    logic [PW-1:0] ram_a;
    logic [PW-1:0] ram_b;
    logic [TW-1:0] ram_rem;
    logic [SW-1:0] rem_ext;
    logic [SW-1:0] elapsed_ext;
    logic [SW-1:0] rem_diff;
    logic          keep;
    logic [SW-1:0] life_ext;
    logic [SW-1:0] life_sat;
    logic [IW-1:0] index_ext;
    logic          index_hit;
    logic [LW-1:0] count_ext;
    logic [RW-1:0] rem_out_ext;

    teet_ram #(
        .WIDTH (DW),
        .DEPTH (MAX_ENTRIES)
    ) u_ram (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    // Field split of a memory word and the expiry compare.
    assign ram_a       = ram_rd_data[DW-1 -: PW];
    assign ram_b       = ram_rd_data[PW+TW-1 -: PW];
    assign ram_rem     = ram_rd_data[TW-1:0];
    assign rem_ext     = SW'(ram_rem);
    assign elapsed_ext = SW'(elapsed_reg);
    assign keep        = rem_ext > elapsed_ext;
    assign rem_diff    = rem_ext - elapsed_ext;

    // Lifetime saturation to the stored time width.
    assign life_ext = SW'(lifetime_ms[teet_pkg::LIFE_W-2:0]);
    assign life_sat = (life_ext > SW'(TIME_MAX)) ? SW'(TIME_MAX) : life_ext;

    // Read index range check against the live count.
    assign index_ext = IW'(read_index);
    assign index_hit = index_ext < IW'(count_reg);

    // Handshake helpers.
    assign in_stall  = (state_reg != teet_pkg::S_IDLE);
    assign in_accept = in_valid && !in_stall;
    assign out_free  = !out_valid_reg || !out_stall;

    // Sequencer: next state, memory access and result hand-off.
    always_comb
    begin
        state_next   = state_reg;
        count_next   = count_reg;
        rd_next      = rd_reg;
        wr_next      = wr_reg;
        pend_next    = pend_reg;
        hit_next     = hit_reg;
        status_next  = status_reg;
        elapsed_next = elapsed_reg;
        ram_wr_en    = 1'b0;
        ram_wr_addr  = '0;
        ram_wr_data  = {endpoint_a[PW-1:0], endpoint_b[PW-1:0], life_sat[TW-1:0]};
        ram_rd_en    = 1'b0;
        ram_rd_addr  = '0;
        out_load     = 1'b0;

        unique case (state_reg)
            teet_pkg::S_IDLE:
            begin
                if (in_valid)
                begin
                    hit_next    = 1'b0;
                    status_next = teet_pkg::STAT_DONE;
                    unique case (teet_pkg::mode_t'(mode))
                        teet_pkg::MODE_ADD:
                        begin
                            state_next = teet_pkg::S_DONE;
                            if (lifetime_ms[teet_pkg::LIFE_W-1])
                            begin
                                status_next = teet_pkg::STAT_NEG;
                            end
                            else if (count_reg == COUNT_FULL)
                            begin
                                status_next = teet_pkg::STAT_FULL;
                            end
                            else
                            begin
                                ram_wr_en   = 1'b1;
                                ram_wr_addr = count_reg[AW-1:0];
                                count_next  = count_reg + CW'(1);
                            end
                        end
                        teet_pkg::MODE_ADV:
                        begin
                            elapsed_next = elapsed_ms;
                            rd_next      = '0;
                            wr_next      = '0;
                            pend_next    = 1'b0;
                            state_next   = (count_reg == '0) ? teet_pkg::S_DONE
                                                             : teet_pkg::S_ADV;
                        end
                        teet_pkg::MODE_READ:
                        begin
                            hit_next    = index_hit;
                            ram_rd_en   = index_hit;
                            ram_rd_addr = index_ext[AW-1:0];
                            state_next  = teet_pkg::S_RDATA;
                        end
                        teet_pkg::MODE_NOP:
                        begin
                            state_next = teet_pkg::S_DONE;
                        end
                    endcase
                end
            end

            teet_pkg::S_ADV:
            begin
                // Read side runs one entry ahead of the write-back side.
                pend_next = rd_reg < count_reg;
                if (rd_reg < count_reg)
                begin
                    ram_rd_en   = 1'b1;
                    ram_rd_addr = rd_reg[AW-1:0];
                    rd_next     = rd_reg + CW'(1);
                end
                // Survivors are written back packed to the front.
                if (pend_reg && keep)
                begin
                    ram_wr_en   = 1'b1;
                    ram_wr_addr = wr_reg[AW-1:0];
                    ram_wr_data = {ram_a, ram_b, rem_diff[TW-1:0]};
                    wr_next     = wr_reg + CW'(1);
                end
                if (rd_reg == count_reg && !pend_reg)
                begin
                    count_next = wr_reg;
                    state_next = teet_pkg::S_DONE;
                end
            end

            teet_pkg::S_RDATA,
            teet_pkg::S_DONE:
            begin
                if (out_free)
                begin
                    out_load   = 1'b1;
                    state_next = teet_pkg::S_IDLE;
                end
            end

            default:
            begin
                state_next = teet_pkg::S_IDLE;
            end
        endcase

        // Output register valid.
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= teet_pkg::S_IDLE;
            count_reg     <= '0;
            rd_reg        <= '0;
            wr_reg        <= '0;
            pend_reg      <= 1'b0;
            hit_reg       <= 1'b0;
            status_reg    <= teet_pkg::STAT_DONE;
            elapsed_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            rd_reg        <= rd_next;
            wr_reg        <= wr_next;
            pend_reg      <= pend_next;
            hit_reg       <= hit_next;
            status_reg    <= status_next;
            elapsed_reg   <= elapsed_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Result payload; read fields are zero unless a read hit a live entry.
    assign count_ext   = LW'(count_reg);
    assign rem_out_ext = RW'(ram_rem);

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_status_reg <= status_reg;
            out_count_reg  <= count_ext[teet_pkg::COUNT_W-1:0];
            out_hit_reg    <= hit_reg;
            out_a_reg      <= hit_reg ? teet_pkg::PORT_PAYLOAD_W'(ram_a) : '0;
            out_b_reg      <= hit_reg ? teet_pkg::PORT_PAYLOAD_W'(ram_b) : '0;
            out_rem_reg    <= hit_reg ? rem_out_ext[teet_pkg::PORT_TIME_W-1:0] : '0;
        end
    end

    assign out_valid         = out_valid_reg;
    assign status            = out_status_reg;
    assign live_count        = out_count_reg;
    assign read_valid        = out_hit_reg;
    assign read_endpoint_a   = out_a_reg;
    assign read_endpoint_b   = out_b_reg;
    assign read_remaining_ms = out_rem_reg;

    // The compaction write pointer never passes the read pointer.
    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == teet_pkg::S_ADV |-> wr_reg <= rd_reg)
        else $error("compaction write pointer passed read pointer");

    // An accepted beat always puts the sequencer to work.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_accept |=> state_reg != teet_pkg::S_IDLE)
        else $error("accepted beat left sequencer idle");

    // Loading a result presents it and frees the input side.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_load |=> out_valid_reg && state_reg == teet_pkg::S_IDLE)
        else $error("result load did not complete the beat");

    // The end of an advance never grows the table.
    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == teet_pkg::S_ADV && rd_reg == count_reg && !pend_reg
        |=> count_reg <= $past(count_reg))
        else $error("advance grew the live count");

    // The live count stays within the table after an add.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_accept && teet_pkg::mode_t'(mode) == teet_pkg::MODE_ADD
        |=> count_reg <= COUNT_FULL)
        else $error("live count exceeds table size");

endmodule

`default_nettype wire

// ===== src/teet_ram.sv =====
`default_nettype none

module teet_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // One write port, one registered read port; read data holds between reads.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire
